[sv/hnl_pkg.sv]
// Package for the half neighbour list builder: widths, payload structs, FSM states.
// No dependencies.
package hnl_pkg;
    localparam int MAX_PARTICLES = 64;
    localparam int POS_W  = 24;
    localparam int LIST_W = 11;
    localparam int CUT_W  = 50;
    localparam int CNT_W  = 7;
    localparam logic [CUT_W-1:0] CUTOFF_RESET = 50'd67108864;
    localparam logic [CNT_W-1:0] COUNT_RESET  = 7'd64;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_SCAN = 1'b1;
    localparam logic CFG_CUTOFF = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [5:0]        particle_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } t_in;

    typedef struct packed {
        logic [5:0]        neighbour_index;
        logic [LIST_W-1:0] list_position;
        logic [LIST_W-1:0] row_start;
        logic [LIST_W-1:0] row_end;
        logic              last;
    } t_out;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef enum logic [1:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_BOUNDS
    } t_state;
endpackage

[sv/hnl_cell.sv]
// One cell of the particle chain: stores one position and, during a scan,
// passes its stored position on to its neighbor. Uses hnl_pkg.
module hnl_cell #(
    parameter int IDX_W = 6,
    parameter int MY_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic [IDX_W-1:0] i_load_index,
    input  hnl_pkg::t_pos  i_load_pos,
    input  logic           i_shift,
    input  hnl_pkg::t_pos  i_prev,
    output hnl_pkg::t_pos  o_pos
);
    hnl_pkg::t_pos r_pos;
    // A scan rotates the chain so the cell at the head sees each particle in turn;
    // the full rotation returns every position to its own cell.
    always_ff @(posedge i_clk) begin
        if (i_load && i_load_index == IDX_W'(MY_IDX)) begin
            r_pos <= i_load_pos;
        end else if (i_shift) begin
            r_pos <= i_prev;
        end
    end
    assign o_pos = r_pos;
endmodule

[sv/hnl_dist.sv]
// Two-stage squared distance compare against the cutoff.
// Uses hnl_pkg.
module hnl_dist (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  hnl_pkg::t_pos                i_a,
    input  hnl_pkg::t_pos                i_b,
    input  logic [hnl_pkg::CUT_W-1:0]    i_cutoff,
    output logic                         o_hit
);
    logic signed [24:0] w_dx, w_dy, w_dz;
    logic [47:0] r_sx, r_sy, r_sz;
    logic [49:0] w_sum;
    logic r_hit;
    assign w_dx = 25'(i_a.x) - 25'(i_b.x);
    assign w_dy = 25'(i_a.y) - 25'(i_b.y);
    assign w_dz = 25'(i_a.z) - 25'(i_b.z);
    // Both stages hold while the sequencer stalls, so they stay in step with its indexes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx  <= 48'(w_dx * w_dx);
            r_sy  <= 48'(w_dy * w_dy);
            r_sz  <= 48'(w_dz * w_dz);
            r_hit <= w_sum < i_cutoff;
        end
    end
    assign w_sum = 50'(r_sx) + 50'(r_sy) + 50'(r_sz);
    assign o_hit = r_hit;
endmodule

[sv/half_neighbour_list_builder_core.sv]
// Top level of the half neighbour list builder: cell chain, distance unit, sequencer.
// Uses hnl_pkg, hnl_cell, hnl_dist.
//
//  channel  direction  handshake          payload
//  input    in         i_valid/o_ready    i_data (t_in)
//  output   out        o_valid/i_ready    o_data (t_out)
//  config   in         i_cfg_we           i_cfg_index, i_cfg_data
//
// A load writes the addressed cell. A scan rotates the cell chain once, then
// drains the distance unit's pipeline and emits the bounds record.
// Each hit waits in the output register; the chain stalls while it is full.
// Synchronous active-low reset clears control state and returns configuration to its defaults.
module half_neighbour_list_builder_core #(
    parameter int MAX_PARTICLES = hnl_pkg::MAX_PARTICLES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  hnl_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output hnl_pkg::t_out             o_data,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [hnl_pkg::CUT_W-1:0] i_cfg_data
);
    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = hnl_pkg::CNT_W;

    logic [hnl_pkg::CUT_W-1:0] r_cutoff;
    logic [hnl_pkg::CNT_W-1:0] r_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= hnl_pkg::CUTOFF_RESET;
            r_count  <= hnl_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hnl_pkg::CFG_CUTOFF: r_cutoff <= i_cfg_data;
                hnl_pkg::CFG_COUNT:  r_count  <= i_cfg_data[hnl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_acc, w_load, w_shift;
    hnl_pkg::t_pos w_load_pos;
    hnl_pkg::t_pos w_pos [MAX_PARTICLES];
    assign w_acc = i_valid && o_ready;
    // A load past the last cell is dropped.
    assign w_load = w_acc && i_data.req_type == hnl_pkg::REQ_LOAD
                 && {1'b0, i_data.particle_index} < CW'(MAX_PARTICLES);
    assign w_load_pos = '{x: i_data.pos_x, y: i_data.pos_y, z: i_data.pos_z};

    // Chain rotates toward cell 0: cell k takes cell k+1, the last takes cell 0.
    for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_cell
        hnl_cell #(.IDX_W(IDX_W), .MY_IDX(k)) u_cell (
            .i_clk(i_clk), .i_load(w_load),
            .i_load_index(i_data.particle_index[IDX_W-1:0]),
            .i_load_pos(w_load_pos), .i_shift(w_shift),
            .i_prev(w_pos[(k + 1) % MAX_PARTICLES]), .o_pos(w_pos[k]));
    end

    hnl_pkg::t_state r_state, n_state;
    hnl_pkg::t_pos r_ref;
    logic [CW-1:0] r_step, r_row, r_n;
    logic [hnl_pkg::LIST_W-1:0] r_run, r_start;
    logic [CW-1:0] r_j1, r_j2;
    logic r_v1, r_v2;
    logic w_hit, w_emit, w_fire, w_adv, w_out_free;
    hnl_pkg::t_out r_out;
    logic r_oval;

    hnl_dist u_dist (.i_clk(i_clk), .i_en(w_adv), .i_a(r_ref), .i_b(w_pos[0]),
        .i_cutoff(r_cutoff), .o_hit(w_hit));

    assign w_out_free = !r_oval || i_ready;
    // Stage 1 sits in the multiply register, stage 2 holds its index for the compare.
    assign w_emit  = r_v2 && w_hit;
    assign w_fire  = w_out_free || !w_emit;
    assign w_adv   = w_fire && r_state != hnl_pkg::S_BOUNDS;
    assign w_shift = r_state == hnl_pkg::S_SCAN && w_fire;
    assign o_ready = r_state == hnl_pkg::S_IDLE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            hnl_pkg::S_IDLE:
                if (w_acc && i_data.req_type == hnl_pkg::REQ_SCAN) n_state = hnl_pkg::S_SCAN;
            hnl_pkg::S_SCAN:
                if (w_fire && r_step == CW'(MAX_PARTICLES - 1)) n_state = hnl_pkg::S_DRAIN;
            hnl_pkg::S_DRAIN:
                if (w_fire && !r_v1) n_state = hnl_pkg::S_BOUNDS;
            hnl_pkg::S_BOUNDS:
                if (w_out_free && !r_v2) n_state = hnl_pkg::S_IDLE;
            default: n_state = hnl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= hnl_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    logic [CW-1:0] w_cnt;
    assign w_cnt = (r_count > hnl_pkg::CNT_W'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES)
                                                             : CW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0; r_v1 <= 1'b0; r_v2 <= 1'b0; r_oval <= 1'b0;
        end else begin
            if (w_acc && i_data.req_type == hnl_pkg::REQ_SCAN) begin
                r_row  <= CW'(i_data.particle_index);
                r_n    <= w_cnt;
                r_step <= '0;
                r_ref  <= w_pos[i_data.particle_index[IDX_W-1:0]];
                if (i_data.particle_index == '0) begin
                    r_run <= '0; r_start <= '0;
                end else begin
                    r_start <= r_run;
                end
            end
            if (w_adv) begin
                // Chain head at step s holds particle s; only later particles in use count.
                r_v1 <= w_shift && r_step > r_row && r_step < r_n;
                r_j1 <= r_step;
                r_v2 <= r_v1;
                r_j2 <= r_j1;
                if (w_shift) r_step <= r_step + CW'(1);
            end else if (r_state == hnl_pkg::S_BOUNDS) begin
                r_v2 <= 1'b0;
            end
            if (w_out_free && w_emit && r_state != hnl_pkg::S_BOUNDS) begin
                r_oval <= 1'b1;
                r_out  <= '{neighbour_index: r_j2[5:0], list_position: r_run,
                            row_start: r_start, row_end: '0, last: 1'b0};
                r_run  <= r_run + 1'b1;
            end else if (r_state == hnl_pkg::S_BOUNDS && w_out_free) begin
                r_oval <= 1'b1;
                r_out  <= '{neighbour_index: '0, list_position: '0,
                            row_start: r_start, row_end: r_run, last: 1'b1};
            end else if (w_out_free) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && !i_ready |=> r_oval && $stable(r_out))
        else $error("output request changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != hnl_pkg::S_IDLE |-> !o_ready)
        else $error("input accepted during a scan");
    a_shift_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> r_state == hnl_pkg::S_SCAN)
        else $error("chain moved outside a scan");
endmodule
